// File: rtl/assert_macros.svh
// Assertion macros used by the checker module of the block.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low asynchronous reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low asynchronous reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/msd_pkg.sv
// Shared widths, codes and types of the mean squared displacement block.
// No dependencies; imported by every module and interface file of the block.
package msd_pkg;

	// Default number of fraction bits of the fixed-point formats.
	localparam int FRAC_BITS_DEF = 16;

	// Field widths of a request and a result.
	localparam int CROSS_W = 16;
	localparam int COORD_W = 16;
	localparam int STEP_W  = 16;
	localparam int OUT_W   = 48;

	// Configuration register widths and port.
	localparam int BOX_W     = 32;
	localparam int ATOM_W    = 17;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	// Datapath widths: scaled length, running sum, shared multiplier digits.
	localparam int LEN_W  = 48;
	localparam int SUM_W  = 64;
	localparam int DIG_W  = LEN_W / 2;
	localparam int PP_W   = 2 * DIG_W;
	localparam int PROD_W = 2 * LEN_W;

	// Divider steps (one quotient bit per step) and their counter.
	localparam int DIV_STEPS = SUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_LEN_X  = 3'd0,
		REG_BOX_LEN_Y  = 3'd1,
		REG_BOX_LEN_Z  = 3'd2,
		REG_ATOM_TOTAL = 3'd3,
		REG_STEP_SIZE  = 3'd4
	} cfg_reg_t;

	// Axis being processed.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// One atom request as handed to the datapath.
	typedef struct packed {
		logic signed [CROSS_W-1:0] cross_x;
		logic signed [CROSS_W-1:0] cross_y;
		logic signed [CROSS_W-1:0] cross_z;
		logic [COORD_W-1:0]        now_x;
		logic [COORD_W-1:0]        now_y;
		logic [COORD_W-1:0]        now_z;
		logic [COORD_W-1:0]        start_x;
		logic [COORD_W-1:0]        start_y;
		logic [COORD_W-1:0]        start_z;
		logic [STEP_W-1:0]         step_index;
		logic                      last_atom;
	} msd_atom_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       op_load;
		logic       sq_pass;
		axis_t      axis;
		logic       acc_clr;
		logic       pp_en;
		logic [1:0] dig;
		logic       acc_add;
		logic       sum_add;
		logic       div_step;
		logic       out_load;
	} msd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last;
		logic out_free;
	} msd_status_t;

endpackage

// File: rtl/msd_if.sv
// Valid/ready channel interfaces for atom requests and frame results.
// Depends on msd_pkg for the field widths.

// Atom request channel.
interface msd_atom_if import msd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [CROSS_W-1:0] cross_x;
	logic signed [CROSS_W-1:0] cross_y;
	logic signed [CROSS_W-1:0] cross_z;
	logic [COORD_W-1:0]        now_x;
	logic [COORD_W-1:0]        now_y;
	logic [COORD_W-1:0]        now_z;
	logic [COORD_W-1:0]        start_x;
	logic [COORD_W-1:0]        start_y;
	logic [COORD_W-1:0]        start_z;
	logic [STEP_W-1:0]         step_index;
	logic                      last_atom;

	modport source (
		output valid, cross_x, cross_y, cross_z, now_x, now_y, now_z,
		output start_x, start_y, start_z, step_index, last_atom,
		input  ready
	);
	modport sink (
		input  valid, cross_x, cross_y, cross_z, now_x, now_y, now_z,
		input  start_x, start_y, start_z, step_index, last_atom,
		output ready
	);
endinterface

// Frame result channel.
interface msd_result_if import msd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] msd_value;
	logic [OUT_W-1:0] frame_time;

	modport source (output valid, msd_value, frame_time, input ready);
	modport sink   (input valid, msd_value, frame_time, output ready);
endinterface

// File: rtl/msd_datapath.sv
// Datapath: configuration registers, displacement magnitudes, the shared
// 24x24 multiplier with its accumulator, the running sum and the divider.
// Depends on msd_pkg; driven by msd_ctrl through msd_cmd_t.
module msd_datapath import msd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  msd_atom_t            atom,
	input  msd_cmd_t             cmd,
	output msd_status_t          status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [OUT_W-1:0]     msd_value,
	output logic [OUT_W-1:0]     frame_time
);

	localparam int MAG_W  = FRAC_BITS + 16;
	localparam int DISP_W = FRAC_BITS + 17;

	// Magnitude of crossings plus current minus initial coordinate, Q.F.
	function automatic logic [MAG_W-1:0] disp_mag(
		input logic signed [CROSS_W-1:0] c,
		input logic [COORD_W-1:0]        n,
		input logic [COORD_W-1:0]        s
	);
		logic signed [DISP_W-1:0] d;
		d = (DISP_W'(c) <<< FRAC_BITS)
			+ $signed({{(DISP_W-COORD_W){1'b0}}, n})
			- $signed({{(DISP_W-COORD_W){1'b0}}, s});
		return d[DISP_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	logic [BOX_W-1:0]  box_x_q, box_y_q, box_z_q;
	logic [ATOM_W-1:0] atom_total_q;
	logic [TIME_W-1:0] step_size_q;

	logic [MAG_W-1:0]  mag_x_q, mag_y_q, mag_z_q;
	logic              last_q;
	logic [OUT_W-1:0]  time_q;

	logic [LEN_W-1:0]  op_a_q, op_b_q;
	logic [PP_W-1:0]   pp_s1;
	logic [1:0]        tag_s1;
	logic [PROD_W-1:0] acc_q;
	logic [SUM_W-1:0]  sum_q;
	logic [ATOM_W-1:0] rem_q;

	logic              out_valid_q;
	logic [OUT_W-1:0]  msd_q, frame_q;

	logic [MAG_W-1:0]  mag_sel;
	logic [BOX_W-1:0]  box_sel;
	logic [LEN_W-1:0]  len;
	logic [SUM_W-1:0]  sq;
	logic [DIG_W-1:0]  a_dig, b_dig;
	logic [PROD_W-1:0] addend;
	logic [SUM_W:0]    sum_ext;
	logic [ATOM_W-1:0] divisor;
	logic [ATOM_W:0]   trial, trial_sub;
	logic              q_bit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q      <= BOX_W'(65536);
			box_y_q      <= BOX_W'(65536);
			box_z_q      <= BOX_W'(65536);
			atom_total_q <= ATOM_W'(1);
			step_size_q  <= TIME_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_LEN_X:  box_x_q      <= cfg_data[BOX_W-1:0];
				REG_BOX_LEN_Y:  box_y_q      <= cfg_data[BOX_W-1:0];
				REG_BOX_LEN_Z:  box_z_q      <= cfg_data[BOX_W-1:0];
				REG_ATOM_TOTAL: atom_total_q <= cfg_data[ATOM_W-1:0];
				REG_STEP_SIZE:  step_size_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture: displacement magnitudes, last flag and frame time.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_x_q <= disp_mag(atom.cross_x, atom.now_x, atom.start_x);
			mag_y_q <= disp_mag(atom.cross_y, atom.now_y, atom.start_y);
			mag_z_q <= disp_mag(atom.cross_z, atom.now_z, atom.start_z);
			last_q  <= atom.last_atom;
			time_q  <= {{(OUT_W-STEP_W){1'b0}}, atom.step_index}
				* {{(OUT_W-TIME_W){1'b0}}, step_size_q};
		end
	end

	// Operand selection for the current axis.
	always_comb begin
		unique case (cmd.axis)
			AXIS_X: begin
				mag_sel = mag_x_q;
				box_sel = box_x_q;
			end
			AXIS_Y: begin
				mag_sel = mag_y_q;
				box_sel = box_y_q;
			end
			AXIS_Z: begin
				mag_sel = mag_z_q;
				box_sel = box_z_q;
			end
			default: begin
				mag_sel = '0;
				box_sel = '0;
			end
		endcase
	end

	// Rescaled length never exceeds 48 bits; the square saturates to 64 bits.
	assign len = acc_q[FRAC_BITS +: LEN_W];
	assign sq  = (|acc_q[PROD_W-1:SUM_W+FRAC_BITS]) ? '1 : acc_q[FRAC_BITS +: SUM_W];

	// Multiplier operands: magnitude times box length, then length squared.
	always_ff @(posedge clk) begin
		if (cmd.op_load) begin
			if (cmd.sq_pass) begin
				op_a_q <= len;
				op_b_q <= len;
			end else begin
				op_a_q <= {{(LEN_W-MAG_W){1'b0}}, mag_sel};
				op_b_q <= {{(LEN_W-BOX_W){1'b0}}, box_sel};
			end
		end
	end

	// Partial product stage of the shared multiplier.
	assign a_dig = cmd.dig[0] ? op_a_q[LEN_W-1:DIG_W] : op_a_q[DIG_W-1:0];
	assign b_dig = cmd.dig[1] ? op_b_q[LEN_W-1:DIG_W] : op_b_q[DIG_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.pp_en) begin
			pp_s1  <= a_dig * b_dig;
			tag_s1 <= {1'b0, cmd.dig[0]} + {1'b0, cmd.dig[1]};
		end
	end

	// Align the partial product by its digit weight.
	always_comb begin
		unique case (tag_s1)
			2'd0:    addend = PROD_W'(pp_s1);
			2'd1:    addend = PROD_W'(pp_s1) << DIG_W;
			2'd2:    addend = PROD_W'(pp_s1) << (2 * DIG_W);
			default: addend = '0;
		endcase
	end

	// Product accumulator.
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + addend;
		end
	end

	// Restoring division step; a zero atom count divides as one.
	assign divisor   = (atom_total_q == '0) ? ATOM_W'(1) : atom_total_q;
	assign trial     = {rem_q, sum_q[SUM_W-1]};
	assign q_bit     = trial >= {1'b0, divisor};
	assign trial_sub = trial - {1'b0, divisor};
	assign sum_ext   = {1'b0, sum_q} + {1'b0, sq};

	// Running sum, which also serves as dividend and quotient register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end else if (cmd.div_step) begin
			sum_q <= {sum_q[SUM_W-2:0], q_bit};
		end else if (cmd.out_load) begin
			sum_q <= '0;
		end
	end

	// Division remainder, cleared with every new request.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? trial_sub[ATOM_W-1:0] : trial[ATOM_W-1:0];
		end
	end

	// Output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: mean saturated to 48 bits and the frame time.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			msd_q   <= (|sum_q[SUM_W-1:OUT_W]) ? '1 : sum_q[OUT_W-1:0];
			frame_q <= time_q;
		end
	end

	assign status.last     = last_q;
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign msd_value       = msd_q;
	assign frame_time      = frame_q;

endmodule

// File: rtl/msd_ctrl.sv
// Controller: sequences the per-axis multiplies, the sum update, the
// division and the result load. Depends on msd_pkg for commands and status.
module msd_ctrl import msd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  msd_status_t status,
	output msd_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_OPLD  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_SUM   = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	axis_t            axis_q, axis_d;
	logic             pass_q, pass_d;
	axis_t            axis_next;

	// Axis order x, y, z.
	always_comb begin
		unique case (axis_q)
			AXIS_X:  axis_next = AXIS_Y;
			AXIS_Y:  axis_next = AXIS_Z;
			default: axis_next = AXIS_X;
		endcase
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		axis_d      = axis_q;
		pass_d      = pass_q;
		cmd         = '0;
		cmd.axis    = axis_q;
		cmd.sq_pass = pass_q;
		cmd.dig     = cnt_q[1:0];
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					axis_d   = AXIS_X;
					pass_d   = 1'b0;
					state_d  = ST_OPLD;
				end
			end
			ST_OPLD: begin
				cmd.op_load = 1'b1;
				cmd.acc_clr = 1'b1;
				cnt_d       = '0;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				cmd.pp_en   = 1'b1;
				cmd.acc_add = cnt_q[1:0] != 2'd0;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q[1:0] == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.acc_add = 1'b1;
				if (!pass_q) begin
					pass_d  = 1'b1;
					state_d = ST_OPLD;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_add = 1'b1;
				if (axis_q == AXIS_Z) begin
					cnt_d   = '0;
					state_d = status.last ? ST_DIV : ST_IDLE;
				end else begin
					axis_d  = axis_next;
					pass_d  = 1'b0;
					state_d = ST_OPLD;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			axis_q  <= AXIS_X;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			axis_q  <= axis_d;
			pass_q  <= pass_d;
		end
	end

endmodule

// File: rtl/mean_squared_displacement.sv
// Top level of the mean squared displacement block: controller and datapath.
// Depends on msd_pkg, msd_atom_if, msd_result_if, msd_ctrl and msd_datapath.
//
//   Channel  Dir  Handshake      Contents
//   atom     in   valid/ready    crossings, coordinates, step index, last flag
//   result   out  valid/ready    msd_value, frame_time
//   cfg      in   cfg_we only    cfg_index, cfg_data
//
// An atom is accepted only in idle, so the next waits for six 48x48
// products, each run as four partial products on the shared 24x24
// multiplier. A last atom also runs the one-bit-per-cycle divider and
// the result load. Reset clears the sum and loads register defaults.
// A stalled result is held in the output register; the next atom is
// accepted meanwhile, and a later frame waits only at its load.
module mean_squared_displacement import msd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	msd_atom_if.sink             atom,
	msd_result_if.source         result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	msd_atom_t   atom_d;
	msd_cmd_t    cmd;
	msd_status_t status;

	// Gather the request payload into one struct.
	assign atom_d = '{
		cross_x:    atom.cross_x,
		cross_y:    atom.cross_y,
		cross_z:    atom.cross_z,
		now_x:      atom.now_x,
		now_y:      atom.now_y,
		now_z:      atom.now_z,
		start_x:    atom.start_x,
		start_y:    atom.start_y,
		start_z:    atom.start_z,
		step_index: atom.step_index,
		last_atom:  atom.last_atom
	};

	msd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (atom.valid),
		.in_ready (atom.ready),
		.status   (status),
		.cmd      (cmd)
	);

	msd_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.atom       (atom_d),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.msd_value  (result.msd_value),
		.frame_time (result.frame_time)
	);

endmodule

// File: rtl/msd_checker.sv
// Port-level checker for the mean squared displacement block, bound to it.
// Depends on msd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module msd_checker import msd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             atom_valid,
	input logic             atom_ready,
	input logic             result_valid,
	input logic             result_ready,
	input logic [OUT_W-1:0] msd_value,
	input logic [OUT_W-1:0] frame_time
);

	// A stalled result keeps its values.
	`ASSERT_NEXT(a_stall_msd, clk, arst_n, result_valid && !result_ready, result_valid && $stable(msd_value), "stalled msd_value changed")
	`ASSERT_NEXT(a_stall_time, clk, arst_n, result_valid && !result_ready, $stable(frame_time), "stalled frame_time changed")

	// An accepted atom keeps the block busy for at least the next cycle.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, atom_valid && atom_ready, !atom_ready, "request accepted back to back")

	// A new result appears only as the block returns to idle.
	`ASSERT_SAME(a_result_at_idle, clk, arst_n, $rose(result_valid), atom_ready, "result loaded while busy")

endmodule

bind mean_squared_displacement msd_checker u_msd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.atom_valid   (atom.valid),
	.atom_ready   (atom.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.msd_value    (result.msd_value),
	.frame_time   (result.frame_time)
);
